[rtl/cfcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_pkg
// Shared types and constants for the capture responder.
// ----------------------------------------------------------------------------
package cfcr_pkg;

  // item command carried on tuser
  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_CANCEL  = 2'd2
  } cmd_t;

  // configuration register indexes
  localparam logic REG_ENABLE      = 1'b0;
  localparam logic REG_REQUEST_BUS = 1'b1;

  localparam int CFG_DATA_W  = 2;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 104;

  localparam logic [28:0] REQ_ID      = 29'h18DABAF1;
  localparam logic [7:0]  RSP_B0      = 8'h07;
  localparam logic [7:0]  RSP_B1      = 8'h62;
  localparam int          MAX_COPY    = 5;
  localparam logic [3:0]  MIN_REQ_LEN = 4'd7;
  localparam logic [3:0]  MAX_LEN     = 4'd8;
  localparam logic [3:0]  NIB_MASK    = 4'hF;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  bus_index;
    logic        extended_frame;
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] payload;
    logic        panel_busy;
    logic [31:0] frame_stamp;
  } item_t;

  typedef struct packed {
    logic        request_accepted;
    logic        response_valid;
    logic [63:0] response_payload;
    logic [31:0] response_timestamp;
  } result_t;

  typedef struct packed {
    logic       enable;
    logic [1:0] request_bus;
  } cfg_t;

endpackage

[rtl/cfcr_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_in_stage
// Input register: unpacks the slave-side beat and holds it for the engine.
// ----------------------------------------------------------------------------
module cfcr_in_stage
  import cfcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  advance,
  output logic                  s_tready,
  output logic                  item_valid,
  output item_t                 item
);

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.command        <= s_tuser;
      item.bus_index      <= s_tdata[1:0];
      item.extended_frame <= s_tdata[2];
      item.frame_id       <= s_tdata[31:3];
      item.frame_length   <= s_tdata[35:32];
      item.payload        <= s_tdata[99:36];
      item.panel_busy     <= s_tdata[100];
      item.frame_stamp    <= s_tdata[132:101];
    end
  end

endmodule

[rtl/cfcr_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_engine
// Arm/capture state and the single-pass result logic for one item.
// ----------------------------------------------------------------------------
module cfcr_engine
  import cfcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    advance,
  output result_t result
);

  logic        armed_flag, armed_flag_next;
  logic        target_is_extended;
  logic [3:0]  byte_offset;
  logic [7:0]  descriptor_byte;
  logic [31:0] target_identifier;

  logic        load_target;
  logic [3:0]  len_sat;
  logic        req_ok;
  logic        tgt_match;
  logic [7:0]  desc_in;
  logic [4:0]  idx [MAX_COPY];
  logic [63:0] copy_pay;

  always_comb begin
    len_sat = (item.frame_length > MAX_LEN) ? MAX_LEN : item.frame_length;
    desc_in = item.payload[23:16];
    req_ok  = cfg.enable && item.extended_frame && (item.bus_index == cfg.request_bus) &&
              (item.frame_id == REQ_ID) && (len_sat >= MIN_REQ_LEN);
    tgt_match = (item.extended_frame == target_is_extended) &&
                ({3'b000, item.frame_id} == target_identifier);

    // bytes copied from the offset, stopping at the frame length
    copy_pay = {40'd0, descriptor_byte, RSP_B1, RSP_B0};
    for (int k = 0; k < MAX_COPY; k++) begin
      idx[k] = {1'b0, byte_offset} + 5'(k);
      if (idx[k] < {1'b0, len_sat}) begin
        copy_pay[(3 + k) * 8 +: 8] = item.payload[{idx[k][2:0], 3'b000} +: 8];
      end
    end

    armed_flag_next = armed_flag;
    load_target     = 1'b0;
    result          = '0;
    case (cmd_t'(item.command))
      CMD_REQUEST: begin
        if (req_ok) begin
          load_target             = 1'b1;
          armed_flag_next         = 1'b1;
          result.request_accepted = 1'b1;
        end
      end
      CMD_CAPTURE: begin
        if (cfg.enable && armed_flag) begin
          if (item.panel_busy) begin
            armed_flag_next = 1'b0;
          end else if (tgt_match) begin
            armed_flag_next = 1'b0;
            if (byte_offset < len_sat) begin
              result.response_valid     = 1'b1;
              result.response_payload   = copy_pay;
              result.response_timestamp = item.frame_stamp;
            end
          end
        end
      end
      CMD_CANCEL: begin
        armed_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag         <= 1'b0;
      target_is_extended <= 1'b0;
      byte_offset        <= '0;
      descriptor_byte    <= '0;
      target_identifier  <= '0;
    end else if (advance) begin
      armed_flag <= armed_flag_next;
      if (load_target) begin
        target_is_extended <= (desc_in[7:4] != 4'd0);
        byte_offset        <= desc_in[3:0] & NIB_MASK;
        descriptor_byte    <= desc_in;
        target_identifier  <= {item.payload[31:24], item.payload[39:32],
                               item.payload[47:40], item.payload[55:48]};
      end
    end
  end

endmodule

[rtl/cfcr_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_out_stage
// Result register driving the master-side beat.
// ----------------------------------------------------------------------------
module cfcr_out_stage
  import cfcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  result_t                result,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   room
);

  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'd0, result.response_timestamp, result.response_payload,
                  result.response_valid, result.request_accepted};
    end
  end

endmodule

[rtl/can_frame_capture_responder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_capture_responder
// One-shot frame snooper: a request arms it, a matching frame is echoed.
// ----------------------------------------------------------------------------
// usage
//   slave side (s_*) takes one frame item per beat; tuser holds the command
//   (request, capture, cancel). master side (m_*) gives exactly one result
//   beat for every input beat, in order.
//   cfg_we/cfg_index/cfg_data write enable (index 0) and request_bus
//   (index 1); write only while no beat is in flight.
// pipeline and throughput
//   an input beat passes the input register, then the result register.
//   one beat per cycle sustained while m_tready stays high: the arm
//   state is updated in the same cycle the result register loads, so
//   the next item sees it at once.
// reset
//   synchronous rst clears both valid flags, the arm state, the stored
//   target and the configuration (service disabled, bus 0).
// stalls
//   when m_tready is low the result beat holds; one more item may wait in
//   the input register, after that s_tready drops.
// ----------------------------------------------------------------------------
module can_frame_capture_responder
  import cfcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input beats
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [1:0] bus_index, [2] extended_frame, [31:3] frame_id, [35:32] frame_length,
  // [99:36] payload, [100] panel_busy, [132:101] frame_stamp, rest zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] command
  input  logic [1:0]             s_tuser,
  // result beats
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] request_accepted, [1] response_valid, [65:2] response_payload,
  // [97:66] response_timestamp, rest zero
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    room;
  logic    advance;

  // an item moves into the result register when there is room for it
  assign advance = item_valid && room;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:      cfg.enable      <= cfg_data[0];
        REG_REQUEST_BUS: cfg.request_bus <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  cfcr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .s_tready   (s_tready),
    .item_valid (item_valid),
    .item       (item)
  );

  // arm state and response build
  cfcr_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  cfcr_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .result   (result),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .room     (room)
  );

endmodule

[rtl/cfcr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cfcr_checker
  import cfcr_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // a beat either arms or responds, never both
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("request_accepted and response_valid both set");

  // no response means zero payload and timestamp
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[97:2] == '0))
    else $error("payload or timestamp set without response_valid");

  // a response starts with the fixed header bytes
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> (m_tdata[9:2] == RSP_B0 && m_tdata[17:10] == RSP_B1))
    else $error("response header bytes wrong");

  // nothing offered right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid after reset");

  // a stalled beat holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

endmodule

bind can_frame_capture_responder cfcr_checker u_cfcr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
